// File: hdl/spadd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial adder package
// Request codes, the transfer payload types and the merge state type that
// the adder's modules share.
// ----------------------------------------------------------------------------
package spadd_pkg;

    // Width of a stored coefficient and of a summed coefficient.
    localparam int COEF_W     = 16;
    localparam int SUM_W      = 17;
    localparam int EXP_OUT_W  = 10;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_LOAD_A = 2'd0;
    localparam logic [1:0] REQ_LOAD_B = 2'd1;
    localparam logic [1:0] REQ_ADD    = 2'd2;

    // Input transfer payload.
    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [COEF_W-1:0] coef_in;
        logic [EXP_OUT_W-1:0]     expon_in;
    } spadd_in_t;

    // Result transfer payload.
    typedef struct packed {
        logic signed [SUM_W-1:0] coef_out;
        logic [EXP_OUT_W-1:0]    expon_out;
        logic                    last_term;
        logic                    empty_result;
        logic                    overflow;
    } spadd_out_t;

    // Status from the merge engine to the load side.
    typedef struct packed {
        logic busy;
        logic done;
    } merge_status_t;

    // Merge sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_FLUSH
    } merge_state_t;

endpackage

// File: hdl/sparse_polynomial_add.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial adder
// Loads two term lists and merges them by exponent into a sum polynomial.
// ----------------------------------------------------------------------------
// Usage: each input transfer carries a request. A load request appends one
// (coefficient, exponent) term to the first or second store and produces no
// result; a term sent to a full store is discarded and the overflow flag is
// set for the next add. An add request starts the merge: s_ready stays low
// until the add has finished. The merge works in steps, a step consuming one
// head term or two heads with equal exponent, at most (terms of first +
// terms of second) steps per add. Each emitted term waits in a holding
// register until the next term is formed or both lists run out, then moves
// to the output register, so the final term can carry last_term; an empty
// sum gives one transfer with empty_result set. When m_ready is low the
// merge holds until the output register frees. When the last term enters
// the output register both stores and the overflow flag clear. Reset
// empties both stores and drops any result. Request code 3 is accepted and
// ignored.
// ----------------------------------------------------------------------------
module sparse_polynomial_add #(
    parameter int MAX_TERMS = 32,
    parameter int EXP_WIDTH = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  spadd_pkg::spadd_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output spadd_pkg::spadd_out_t m_data
);

    import spadd_pkg::*;

    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int DW = COEF_W + EXP_WIDTH;

    logic [CW-1:0] cnt_a_reg, cnt_a_next;
    logic [CW-1:0] cnt_b_reg, cnt_b_next;
    logic          dropped_reg, dropped_next;

    merge_status_t                  status;
    logic                           accept, start;
    logic                           load_a, load_b, full_a, full_b;
    logic                           wr_a, wr_b;
    logic [EXP_WIDTH+EXP_OUT_W-1:0] exp_wide;
    logic [DW-1:0]                  wr_term;
    logic [AW-1:0]                  rd_addr_a, rd_addr_b;
    logic [DW-1:0]                  rd_data_a, rd_data_b;

    // Request decode.
    assign s_ready  = !status.busy;
    assign accept   = s_valid && s_ready;
    assign load_a   = accept && (s_data.req_type == REQ_LOAD_A);
    assign load_b   = accept && (s_data.req_type == REQ_LOAD_B);
    assign start    = accept && (s_data.req_type == REQ_ADD);
    assign full_a   = (cnt_a_reg >= CW'(MAX_TERMS));
    assign full_b   = (cnt_b_reg >= CW'(MAX_TERMS));
    assign wr_a     = load_a && !full_a;
    assign wr_b     = load_b && !full_b;

    // Stored term: coefficient above the exponent kept to EXP_WIDTH bits.
    assign exp_wide = {{EXP_WIDTH{1'b0}}, s_data.expon_in};
    assign wr_term  = {s_data.coef_in, exp_wide[EXP_WIDTH-1:0]};

    // Fill counts and the sticky drop flag.
    always_comb begin
        cnt_a_next   = cnt_a_reg;
        cnt_b_next   = cnt_b_reg;
        dropped_next = dropped_reg;
        if (status.done) begin
            cnt_a_next   = '0;
            cnt_b_next   = '0;
            dropped_next = 1'b0;
        end else begin
            if (wr_a) begin
                cnt_a_next = cnt_a_reg + CW'(1);
            end
            if (wr_b) begin
                cnt_b_next = cnt_b_reg + CW'(1);
            end
            if ((load_a && full_a) || (load_b && full_b)) begin
                dropped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_a_reg   <= '0;
            cnt_b_reg   <= '0;
            dropped_reg <= 1'b0;
        end else begin
            cnt_a_reg   <= cnt_a_next;
            cnt_b_reg   <= cnt_b_next;
            dropped_reg <= dropped_next;
        end
    end

    // Term stores.
    spadd_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_TERMS)
    ) u_store_a (
        .aclk    (aclk),
        .wr_en   (wr_a),
        .wr_addr (cnt_a_reg[AW-1:0]),
        .wr_data (wr_term),
        .rd_addr (rd_addr_a),
        .rd_data (rd_data_a)
    );

    spadd_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_TERMS)
    ) u_store_b (
        .aclk    (aclk),
        .wr_en   (wr_b),
        .wr_addr (cnt_b_reg[AW-1:0]),
        .wr_data (wr_term),
        .rd_addr (rd_addr_b),
        .rd_data (rd_data_b)
    );

    // Merge engine.
    spadd_merge #(
        .MAX_TERMS (MAX_TERMS),
        .EXP_WIDTH (EXP_WIDTH)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .cnt_a     (cnt_a_reg),
        .cnt_b     (cnt_b_reg),
        .dropped   (dropped_reg),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: hdl/spadd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic term store RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spadd_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 32
) (
    input  logic                                       aclk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hdl/spadd_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial merge engine
// Walks both term stores with one shared exponent comparator and one
// coefficient adder, holds the newest term back one step so the final term
// can be marked, and drives the result output register.
// ----------------------------------------------------------------------------
module spadd_merge #(
    parameter int MAX_TERMS = 32,
    parameter int EXP_WIDTH = 10
) (
    input  logic                                                 aclk,
    input  logic                                                 aresetn,
    input  logic                                                 start,
    input  logic [$clog2(MAX_TERMS + 1)-1:0]                     cnt_a,
    input  logic [$clog2(MAX_TERMS + 1)-1:0]                     cnt_b,
    input  logic                                                 dropped,
    output logic [((MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1)-1:0] rd_addr_a,
    output logic [((MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1)-1:0] rd_addr_b,
    input  logic [spadd_pkg::COEF_W+EXP_WIDTH-1:0]               rd_data_a,
    input  logic [spadd_pkg::COEF_W+EXP_WIDTH-1:0]               rd_data_b,
    output spadd_pkg::merge_status_t                             status,
    output logic                                                 m_valid,
    input  logic                                                 m_ready,
    output spadd_pkg::spadd_out_t                                m_data
);

    import spadd_pkg::*;

    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int EW = EXP_WIDTH;

    merge_state_t state_reg, state_next;

    logic [CW-1:0]           ia_reg, ia_next;
    logic [CW-1:0]           ib_reg, ib_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic signed [SUM_W-1:0] pend_coef_reg, pend_coef_next;
    logic [EW-1:0]           pend_exp_reg, pend_exp_next;
    logic                    m_valid_reg, m_valid_next;
    spadd_out_t              m_data_reg, m_data_next;

    logic                     a_ok, b_ok;
    logic signed [COEF_W-1:0] coef_a, coef_b;
    logic [EW-1:0]            exp_a, exp_b;
    logic                     a_gt, exp_eq;
    logic                     take_a, take_b, pair;
    logic signed [SUM_W-1:0]  op_a, op_b, sum;
    logic [EW-1:0]            term_exp;
    logic                     emit, out_free, step, finished;
    logic [EW+EXP_OUT_W-1:0]  pend_exp_wide;

    // Unpack the heads of both lists.
    assign coef_a = rd_data_a[COEF_W+EW-1:EW];
    assign exp_a  = rd_data_a[EW-1:0];
    assign coef_b = rd_data_b[COEF_W+EW-1:EW];
    assign exp_b  = rd_data_b[EW-1:0];

    // Shared compare and add unit: one head is taken, or both are summed.
    always_comb begin
        a_ok     = (ia_reg < cnt_a);
        b_ok     = (ib_reg < cnt_b);
        a_gt     = (exp_a > exp_b);
        exp_eq   = (exp_a == exp_b);
        take_a   = a_ok && (!b_ok || a_gt);
        take_b   = b_ok && (!a_ok || (!a_gt && !exp_eq));
        pair     = !take_a && !take_b;
        op_a     = take_b ? '0 : SUM_W'(coef_a);
        op_b     = take_a ? '0 : SUM_W'(coef_b);
        sum      = op_a + op_b;
        term_exp = take_b ? exp_b : exp_a;
        emit     = !pair || (sum != '0);
        out_free = !m_valid_reg || m_ready;
        finished = !a_ok && !b_ok;
        step     = (state_reg == ST_MERGE) && !finished &&
                   !(emit && pend_valid_reg && !out_free);
    end

    assign pend_exp_wide = {{EXP_OUT_W{1'b0}}, pend_exp_reg};

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE: begin
                if (finished) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Indices, held-back term and output register.
    always_comb begin
        ia_next         = ia_reg;
        ib_next         = ib_reg;
        pend_valid_next = pend_valid_reg;
        pend_coef_next  = pend_coef_reg;
        pend_exp_next   = pend_exp_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        status.busy     = (state_reg != ST_IDLE);
        status.done     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                ia_next = '0;
                ib_next = '0;
            end
            ST_MERGE: begin
                if (step) begin
                    ia_next = ia_reg + CW'(take_a || pair);
                    ib_next = ib_reg + CW'(take_b || pair);
                    if (emit) begin
                        if (pend_valid_reg) begin
                            m_valid_next           = 1'b1;
                            m_data_next.coef_out     = pend_coef_reg;
                            m_data_next.expon_out    = pend_exp_wide[EXP_OUT_W-1:0];
                            m_data_next.last_term    = 1'b0;
                            m_data_next.empty_result = 1'b0;
                            m_data_next.overflow     = dropped;
                        end
                        pend_valid_next = 1'b1;
                        pend_coef_next  = sum;
                        pend_exp_next   = term_exp;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    status.done              = 1'b1;
                    ia_next                  = '0;
                    ib_next                  = '0;
                    pend_valid_next          = 1'b0;
                    m_valid_next             = 1'b1;
                    m_data_next.last_term    = 1'b1;
                    m_data_next.overflow     = dropped;
                    if (pend_valid_reg) begin
                        m_data_next.coef_out     = pend_coef_reg;
                        m_data_next.expon_out    = pend_exp_wide[EXP_OUT_W-1:0];
                        m_data_next.empty_result = 1'b0;
                    end else begin
                        m_data_next.coef_out     = '0;
                        m_data_next.expon_out    = '0;
                        m_data_next.empty_result = 1'b1;
                    end
                end
            end
            default: begin
                ia_next = '0;
                ib_next = '0;
            end
        endcase
    end

    // Read one step ahead so the head data is ready when it is used.
    assign rd_addr_a = ia_next[AW-1:0];
    assign rd_addr_b = ib_next[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ia_reg         <= '0;
            ib_reg         <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ia_reg         <= ia_next;
            ib_reg         <= ib_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        pend_coef_reg <= pend_coef_next;
        pend_exp_reg  <= pend_exp_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial adder testbench
// Loads pairs of term lists into the adder and requests their sum. A
// scoreboard class keeps its own copy of both term stores and works out the
// merged sum terms for every accepted add. Each result transfer is then
// compared field by field with the oldest expected term. Both handshakes idle
// at random, with stretches of back-to-back traffic.
// ----------------------------------------------------------------------------
module tb;
    import spadd_pkg::*;

    localparam int         STORE_DEPTH = 32;
    localparam int         RAND_ITEMS  = 230;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;

    // Tracks both term stores and the sum terms still owed by the adder.
    class poly_sum_board;
        logic signed [COEF_W-1:0] coef_store[2][STORE_DEPTH];
        logic [EXP_OUT_W-1:0]     expon_store[2][STORE_DEPTH];
        int                       term_count[2];
        bit                       dropped;
        spadd_out_t               expected_terms[$];
        int                       mismatch_count;

        function new();
            term_count[0]  = 0;
            term_count[1]  = 0;
            dropped        = 1'b0;
            mismatch_count = 0;
        endfunction

        function int pending();
            return expected_terms.size();
        endfunction

        // Queues one sum term carrying the current drop flag.
        function void push_term(ref spadd_out_t terms[$], input logic signed [SUM_W-1:0] coef,
                                input logic [EXP_OUT_W-1:0] expon);
            spadd_out_t t;
            t.coef_out     = coef;
            t.expon_out    = expon;
            t.last_term    = 1'b0;
            t.empty_result = 1'b0;
            t.overflow     = dropped;
            terms.push_back(t);
        endfunction

        // Merges both stores by exponent, highest first.
        function void merge_stores();
            spadd_out_t               terms[$];
            logic signed [SUM_W-1:0]  sa;
            logic signed [SUM_W-1:0]  sb;
            int                       ia;
            int                       ib;
            ia = 0;
            ib = 0;
            while (ia < term_count[0] || ib < term_count[1]) begin
                sa = (ia < term_count[0]) ? SUM_W'(coef_store[0][ia]) : '0;
                sb = (ib < term_count[1]) ? SUM_W'(coef_store[1][ib]) : '0;
                if (ib >= term_count[1] ||
                    (ia < term_count[0] && expon_store[0][ia] > expon_store[1][ib])) begin
                    push_term(terms, sa, expon_store[0][ia]);
                    ia++;
                end else if (ia >= term_count[0] || expon_store[1][ib] > expon_store[0][ia]) begin
                    push_term(terms, sb, expon_store[1][ib]);
                    ib++;
                end else begin
                    // Equal exponents: a zero sum leaves no term.
                    if (sa + sb != 0) begin
                        push_term(terms, sa + sb, expon_store[0][ia]);
                    end
                    ia++;
                    ib++;
                end
            end
            if (terms.size() == 0) begin
                push_term(terms, '0, '0);
                terms[0].empty_result = 1'b1;
            end
            terms[terms.size() - 1].last_term = 1'b1;
            foreach (terms[i]) expected_terms.push_back(terms[i]);
            term_count[0] = 0;
            term_count[1] = 0;
            dropped       = 1'b0;
        endfunction

        // Notes one accepted request.
        function void note_request(spadd_in_t item);
            int side;
            case (item.req_type)
                REQ_LOAD_A, REQ_LOAD_B: begin
                    side = (item.req_type == REQ_LOAD_A) ? 0 : 1;
                    if (term_count[side] >= STORE_DEPTH) begin
                        dropped = 1'b1;
                    end else begin
                        coef_store[side][term_count[side]]  = item.coef_in;
                        expon_store[side][term_count[side]] = item.expon_in;
                        term_count[side]++;
                    end
                end
                REQ_ADD: merge_stores();
                default: ;
            endcase
        endfunction

        // Compares one result transfer with the oldest expected term.
        function void check_term(spadd_out_t got);
            spadd_out_t want;
            if (expected_terms.size() == 0) begin
                $display("%0t: unexpected result coef %0d expon %0d last %b empty %b ovf %b",
                         $time, got.coef_out, got.expon_out, got.last_term,
                         got.empty_result, got.overflow);
                mismatch_count++;
                return;
            end
            want = expected_terms.pop_front();
            if (got.coef_out !== want.coef_out || got.expon_out !== want.expon_out ||
                got.last_term !== want.last_term || got.empty_result !== want.empty_result ||
                got.overflow !== want.overflow) begin
                $display("%0t: expected coef %0d expon %0d last %b empty %b ovf %b", $time,
                         want.coef_out, want.expon_out, want.last_term, want.empty_result,
                         want.overflow);
                $display("%0t:   actual coef %0d expon %0d last %b empty %b ovf %b", $time,
                         got.coef_out, got.expon_out, got.last_term, got.empty_result,
                         got.overflow);
                mismatch_count++;
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    spadd_in_t  s_data;
    logic       m_valid;
    logic       m_ready;
    spadd_out_t m_data;

    poly_sum_board board;
    int            loads_and_adds;
    bit            send_eager;
    bit            recv_eager;

    sparse_polynomial_add uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Idle length for one transfer; eager mode gives back-to-back stretches.
    function automatic int draw_wait(inout bit eager);
        if ($urandom_range(0, 15) == 0) eager = !eager;
        return eager ? 0 : $urandom_range(0, 10);
    endfunction

    // Sends one request and notes it once the transfer happens.
    task automatic send_request(input logic [1:0] req, input logic signed [COEF_W-1:0] coef,
                                input logic [EXP_OUT_W-1:0] expon);
        spadd_in_t item;
        int        gap;
        item.req_type = req;
        item.coef_in  = coef;
        item.expon_in = expon;
        gap = draw_wait(send_eager);
        repeat (gap) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        board.note_request(item);
        if (req != REQ_UNUSED) loads_and_adds++;
    endtask

    // Holds the input side until every expected term has come back.
    task automatic wait_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
    endtask

    function automatic int draw_length();
        int r;
        r = $urandom_range(0, 14);
        if (r == 0) return $urandom_range(30, 36);
        if (r == 1) return 0;
        return $urandom_range(1, 8);
    endfunction

    function automatic logic signed [COEF_W-1:0] draw_coef();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 4))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return '0;
                    3: return 16'sd1;
                    default: return -16'sd1;
                endcase
            end
            1, 2: return COEF_W'($urandom_range(0, 20) - 10);
            default: return COEF_W'($urandom);
        endcase
    endfunction

    // Loads a pair of lists, mostly with falling exponents, in random interleaving, then adds.
    task automatic run_poly_pair();
        logic [EXP_OUT_W-1:0]     exp_a[$];
        logic [EXP_OUT_W-1:0]     exp_b[$];
        logic signed [COEF_W-1:0] cf_a[$];
        logic signed [COEF_W-1:0] cf_b[$];
        logic signed [COEF_W-1:0] c;
        int                       len_a;
        int                       len_b;
        int                       span;
        int                       lo;
        int                       pos;
        int                       na;
        int                       nb;
        bit                       scrambled;
        len_a = draw_length();
        len_b = draw_length();
        span  = 3 * ((len_a > len_b) ? len_a : len_b) + 4;
        case ($urandom_range(0, 3))
            0: lo = 0;
            1: lo = 1023 - span;
            default: lo = $urandom_range(0, 1023 - span);
        endcase
        scrambled = ($urandom_range(0, 9) == 0);

        // Both lists share one exponent window so that many exponents meet.
        pos = lo + span;
        for (int k = 0; k < len_a; k++) begin
            pos -= $urandom_range(1, 3);
            exp_a.push_back(EXP_OUT_W'(scrambled ? $urandom_range(lo, lo + span) : pos));
            cf_a.push_back(draw_coef());
        end
        pos = lo + span;
        for (int k = 0; k < len_b; k++) begin
            pos -= $urandom_range(1, 3);
            exp_b.push_back(EXP_OUT_W'(scrambled ? $urandom_range(lo, lo + span) : pos));
            c = draw_coef();
            foreach (exp_a[j]) begin
                if (exp_a[j] == exp_b[k] && $urandom_range(0, 1) == 1) c = -cf_a[j];
            end
            cf_b.push_back(c);
        end

        na = 0;
        nb = 0;
        while (na < len_a || nb < len_b) begin
            if (nb >= len_b || (na < len_a && $urandom_range(0, 1) == 1)) begin
                send_request(REQ_LOAD_A, cf_a[na], exp_a[na]);
                na++;
            end else begin
                send_request(REQ_LOAD_B, cf_b[nb], exp_b[nb]);
                nb++;
            end
            if ($urandom_range(0, 24) == 0) begin
                send_request(REQ_UNUSED, COEF_W'($urandom), EXP_OUT_W'($urandom));
            end
        end
        if ($urandom_range(0, 5) == 0) wait_until_drained();
        send_request(REQ_ADD, COEF_W'($urandom), EXP_OUT_W'($urandom));
    endtask

    // Result side: random stalls, every transfer checked.
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = draw_wait(recv_eager);
            repeat (stall) begin
                m_ready <= 1'b0;
                @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            board.check_term(m_data);
        end
    end

    // Stimulus and end of run.
    initial begin
        board          = new();
        loads_and_adds = 0;
        send_eager     = 1'b0;
        recv_eager     = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        aresetn        = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Add with both stores empty gives the empty sum.
        send_request(REQ_ADD, '0, '0);

        // Extreme coefficients and exponents, a zero term, a cancelling pair.
        send_request(REQ_LOAD_A, 16'sh7FFF, 10'd1023);
        send_request(REQ_LOAD_B, 16'sh7FFF, 10'd1023);
        send_request(REQ_LOAD_A, '0, 10'd800);
        send_request(REQ_LOAD_A, 16'sh8000, 10'd512);
        send_request(REQ_LOAD_B, 16'sh8000, 10'd512);
        send_request(REQ_LOAD_B, 16'sd1, 10'd300);
        send_request(REQ_UNUSED, 16'shFFFF, 10'h3FF);
        send_request(REQ_LOAD_A, 16'sd5, 10'd0);
        send_request(REQ_LOAD_B, -16'sd5, 10'd0);
        send_request(REQ_ADD, '0, '0);

        // Every term cancels, so the sum is empty.
        send_request(REQ_LOAD_A, 16'sd100, 10'd10);
        send_request(REQ_LOAD_B, -16'sd100, 10'd10);
        send_request(REQ_ADD, '0, '0);

        // Lists loaded out of order are merged as stored.
        send_request(REQ_LOAD_A, 16'sd1, 10'd5);
        send_request(REQ_LOAD_A, 16'sd2, 10'd9);
        send_request(REQ_LOAD_B, 16'sd3, 10'd7);
        send_request(REQ_ADD, '0, '0);

        // Only the second list holds terms.
        send_request(REQ_LOAD_B, -16'sd7, 10'h2AA);
        send_request(REQ_LOAD_B, 16'sd9, 10'h155);
        send_request(REQ_ADD, 16'shFFFF, 10'h3FF);

        wait_until_drained();

        // Random polynomial pairs.
        loads_and_adds = 0;
        while (loads_and_adds < RAND_ITEMS) run_poly_pair();

        wait_until_drained();
        repeat (40) @(posedge aclk);
        if (board.mismatch_count == 0 && board.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #20000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
